>>> rtl/cecf_pkg.sv
// Shared types, byte codes and the CRC byte step for the escaped chunk framer.
// No dependencies; imported by every module of the block.
`default_nettype none

package cecf_pkg;

   localparam int FRAME_BYTES_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

   localparam logic [7:0] BYTE_ESC    = 8'h99;
   localparam logic [7:0] BYTE_PAD    = 8'h9A;
   localparam logic [7:0] BYTE_HDR    = 8'h9B;
   localparam logic [7:0] BYTE_FINAL  = 8'h9C;
   localparam logic [7:0] BYTE_TRAIL  = 8'h9D;
   localparam logic [7:0] ESC_FLIP    = 8'h10;

   // One byte handed from front to back.
   typedef struct packed {
      logic [7:0] data;     // raw byte, escaped by the back end
      logic       closing;  // last CRC byte: closes the message
      logic       eor;      // last entry of its input item
   } q_entry_type;

   function automatic logic needs_escape(input logic [7:0] b);
      return (b >= BYTE_ESC) && (b <= BYTE_TRAIL);
   endfunction

   // Reflected CRC-32, one byte, bitwise.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cecf_front.sv
// Front end: accepts message bytes, runs the CRC and queues the bytes to send,
// followed by the four CRC bytes after a message's last byte. Uses cecf_pkg.
`default_nettype none

module cecf_front
   import cecf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic        q_full,
   output logic             q_push,
   output q_entry_type      q_entry
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] crc_out_ff, crc_out_in;
   logic [1:0]  idx_ff, idx_in;
   logic        busy_ff, busy_in;
   logic        accept;
   logic [31:0] crc_next;

   assign req_full = busy_ff | q_full;
   assign accept   = req_push & ~req_full;
   assign crc_next = crc_byte(crc_ff, req_data_byte);

   always_comb begin
      crc_in     = crc_ff;
      crc_out_in = crc_out_ff;
      idx_in     = idx_ff;
      busy_in    = busy_ff;
      q_push     = 1'b0;
      q_entry    = '{data: req_data_byte, closing: 1'b0, eor: ~req_last_byte};
      if (busy_ff) begin
         // trailing CRC bytes, least significant first
         q_entry = '{data: crc_out_ff[7:0], closing: (idx_ff == 2'd3),
                     eor: (idx_ff == 2'd3)};
         if (!q_full) begin
            q_push     = 1'b1;
            crc_out_in = crc_out_ff >> 8;
            idx_in     = idx_ff + 2'd1;
            busy_in    = (idx_ff != 2'd3);
         end
      end else if (accept) begin
         q_push = 1'b1;
         if (req_last_byte) begin
            crc_in     = CRC_PRESET;
            crc_out_in = ~crc_next;
            idx_in     = 2'd0;
            busy_in    = 1'b1;
         end else begin
            crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_PRESET;
         idx_ff  <= 2'd0;
         busy_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
      crc_out_ff <= crc_out_in;
   end

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> req_full)
      else $error("front accepts while CRC bytes pending");

   a_crc_preset: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte) |=> (crc_ff == CRC_PRESET) && busy_ff)
      else $error("CRC not preset after last byte");

   a_busy_len: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && q_push && idx_ff == 2'd3) |=> !busy_ff)
      else $error("CRC tail too long");

endmodule

`default_nettype wire

>>> rtl/cecf_queue.sv
// Short first-in first-out queue of byte entries between front and back end.
// Uses cecf_pkg for the entry type.
`default_nettype none

module cecf_queue
   import cecf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire q_entry_type push_entry,
   output logic             full,
   input  wire logic        pop,
   output q_entry_type      pop_entry,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   q_entry_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign empty     = (count_ff == '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;
   assign pop_entry = mem_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? ((wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop  ? ((rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) mem_ff[wr_ff] <= push_entry;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue over-filled");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      empty |-> (wr_ff == rd_ff))
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> rtl/cecf_back.sv
// Back end: escapes queued bytes, frames them with header, trailer and padding,
// and drives the result output register. Uses cecf_pkg.
`default_nettype none

module cecf_back
   import cecf_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire q_entry_type q_entry,
   input  wire logic        q_empty,
   output logic             q_pop,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_frame_end,
   output logic             rsp_end_of_run
);

   localparam int SLOTS  = FRAME_BYTES - 2;
   localparam int FILL_W = $clog2(SLOTS + 1);
   localparam logic [FILL_W-1:0] SLOTS_F = FILL_W'(SLOTS);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_HDR   = 3'd1;
   localparam logic [2:0] ST_BYTE  = 3'd2;
   localparam logic [2:0] ST_TRAIL = 3'd3;
   localparam logic [2:0] ST_PAD   = 3'd4;
   localparam logic [2:0] ST_FINAL = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        data_ff, data_in;
   logic [7:0]        slot_ff, slot_in;
   logic              second_ff, second_in;
   logic              closing_ff, closing_in;
   logic              eor_ff, eor_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_fe_ff, out_fe_in;
   logic              out_eor_ff, out_eor_in;

   logic              emit_ok, emit, e_fe, e_done, slot_done, esc;
   logic [7:0]        e_byte;
   logic [FILL_W-1:0] fill_inc, fill_after;

   assign emit_ok  = ~out_valid_ff | rsp_pop;
   assign fill_inc = fill_ff + 1'b1;
   assign esc      = needs_escape(q_entry.data);

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      data_in    = data_ff;
      slot_in    = slot_ff;
      second_in  = second_ff;
      closing_in = closing_ff;
      eor_in     = eor_ff;
      q_pop      = 1'b0;
      emit       = 1'b0;
      e_byte     = BYTE_PAD;
      e_fe       = 1'b0;
      e_done     = 1'b0;
      slot_done  = 1'b0;
      fill_after = fill_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               data_in    = q_entry.data;
               closing_in = q_entry.closing;
               eor_in     = q_entry.eor;
               second_in  = esc;
               slot_in    = esc ? BYTE_ESC : q_entry.data;
               state_in   = (fill_ff == '0) ? ST_HDR : ST_BYTE;
            end
         end
         ST_HDR: begin
            if (emit_ok) begin
               emit     = 1'b1;
               e_byte   = BYTE_HDR;
               state_in = ST_BYTE;
            end
         end
         ST_BYTE: begin
            if (emit_ok) begin
               emit   = 1'b1;
               e_byte = slot_ff;
               if (fill_inc == SLOTS_F) begin
                  fill_in  = '0;
                  state_in = ST_TRAIL;
               end else begin
                  fill_in    = fill_inc;
                  fill_after = fill_inc;
                  slot_done  = 1'b1;
               end
            end
         end
         ST_TRAIL: begin
            if (emit_ok) begin
               emit       = 1'b1;
               e_fe       = 1'b1;
               // only the message's very last slot closes with the final code
               e_byte     = (closing_ff && !second_ff) ? BYTE_FINAL : BYTE_TRAIL;
               fill_after = '0;
               slot_done  = 1'b1;
            end
         end
         ST_PAD: begin
            if (emit_ok) begin
               emit   = 1'b1;
               e_byte = BYTE_PAD;
               if (fill_inc == SLOTS_F) begin
                  fill_in  = '0;
                  state_in = ST_FINAL;
               end else begin
                  fill_in = fill_inc;
               end
            end
         end
         ST_FINAL: begin
            if (emit_ok) begin
               emit     = 1'b1;
               e_byte   = BYTE_FINAL;
               e_fe     = 1'b1;
               e_done   = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase

      // what follows a finished slot
      if (slot_done) begin
         if (second_ff) begin
            second_in = 1'b0;
            slot_in   = data_ff ^ ESC_FLIP;
            state_in  = (fill_after == '0) ? ST_HDR : ST_BYTE;
         end else if (closing_ff && fill_after != '0) begin
            state_in = ST_PAD;
         end else begin
            e_done   = 1'b1;
            state_in = ST_LOAD;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_pop;
      out_byte_in  = out_byte_ff;
      out_fe_in    = out_fe_ff;
      out_eor_in   = out_eor_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = e_byte;
         out_fe_in    = e_fe;
         out_eor_in   = eor_ff & e_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
      data_ff     <= data_in;
      slot_ff     <= slot_in;
      second_ff   <= second_in;
      closing_ff  <= closing_in;
      eor_ff      <= eor_in;
      out_byte_ff <= out_byte_in;
      out_fe_ff   <= out_fe_in;
      out_eor_ff  <= out_eor_in;
   end

   assign rsp_empty      = ~out_valid_ff;
   assign rsp_tx_byte    = out_byte_ff;
   assign rsp_frame_end  = out_fe_ff;
   assign rsp_end_of_run = out_eor_ff;

   a_trailer_code: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_fe_ff) |-> (out_byte_ff == BYTE_FINAL || out_byte_ff == BYTE_TRAIL))
      else $error("frame end on a non-trailer byte");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < SLOTS_F)
      else $error("frame fill out of range");

   a_pad_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD) |-> (fill_ff != '0))
      else $error("padding a frame that is not open");

   a_eor_frame: assert property (@(posedge clock) disable iff (reset)
      (emit && e_done && closing_ff) |-> e_fe)
      else $error("message ends without closing its frame");

endmodule

`default_nettype wire

>>> rtl/crc32_escaped_chunk_framer.sv
// Top level of the escaped, CRC-protected chunk framer: front end, entry
// queue and back end. Depends on cecf_pkg, cecf_front, cecf_queue, cecf_back.
//
//   channel   direction  handshake          payload
//   req_      in         req_push/req_full  req_data_byte[7:0], req_last_byte
//   rsp_      out        rsp_pop/rsp_empty  rsp_tx_byte[7:0], rsp_frame_end,
//                                           rsp_end_of_run
//
// Flow: the front takes a byte per cycle (CRC one byte a cycle) unless the
// queue is full; a last byte then holds the front while it queues the four
// CRC bytes. The back end loads an entry, then emits its output bytes (header,
// escaped pair, trailer, padding as needed) and loads no new entry until they
// are out; a held output register stalls it.
// Reset: synchronous, active high; CRC back to all ones, frame closed, queue
// and output register empty. Stalls: rsp_pop low holds the output register;
// the queue lets the front keep accepting meanwhile until it fills.
`default_nettype none

module crc32_escaped_chunk_framer
   import cecf_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF,  // 4 to 32
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_frame_end,
   output logic            rsp_end_of_run
);

   q_entry_type push_entry, pop_entry;
   logic        q_push, q_full, q_pop, q_empty;

   // front: CRC and queueing of message and CRC bytes
   cecf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   // decouples the two sides
   cecf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   // back: escaping, framing, padding, output register
   cecf_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_entry        (pop_entry),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_end_of_run (rsp_end_of_run)
   );

   a_hdr_no_flags: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_tx_byte == BYTE_HDR) |-> !rsp_frame_end && !rsp_end_of_run)
      else $error("flags on a frame header");

   // a final trailer is always the last byte of the message's last item
   a_final_ends_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end && rsp_tx_byte == BYTE_FINAL) |-> rsp_end_of_run)
      else $error("final trailer not at end of item");

   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_tx_byte)
         && $stable(rsp_frame_end) && $stable(rsp_end_of_run)))
      else $error("waiting item changed");

endmodule

`default_nettype wire
